// ===== hw/rtl/gip_pkg.sv =====
`default_nettype none

package gip_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;

   localparam int COUNT_W     = 11;
   localparam int COL_W       = 10;
   localparam int ROW_IN_W    = 10;
   localparam int IDX_W       = 20;
   localparam int GRID_W      = 21;
   localparam int STEP_W      = 32;
   localparam int LAYOUT_W    = 3;
   localparam int POS_W       = 49;
   localparam int SUM_W       = 56;
   localparam int COL_FAC_W   = 12;
   localparam int ROW_FAC_W   = 22;
   localparam int COL_OFF_W   = COL_FAC_W + STEP_W;
   localparam int ROW_OFF_W   = ROW_FAC_W + STEP_W;

   localparam int DIV_STAGES  = 5;
   localparam int DIV_BITS    = IDX_W / DIV_STAGES;

   // pipeline stage numbers
   localparam int STG_IN      = 0;
   localparam int STG_IDX     = 1;
   localparam int STG_DIV     = 2;
   localparam int STG_FAC     = STG_DIV + DIV_STAGES;
   localparam int STG_MUL     = STG_FAC + 1;
   localparam int STG_OUT     = STG_MUL + 1;
   localparam int NUM_STAGES  = STG_OUT + 1;

   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 184;
   localparam int RSP_PAD_W   = RSP_DATA_W - (COL_W + IDX_W + 3 * POS_W);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COLUMN_COUNT = 3'd0,
      CSR_ROW_COUNT    = 3'd1,
      CSR_COLUMN_STEP  = 3'd2,
      CSR_ROW_STEP     = 3'd3,
      CSR_LAYOUT       = 3'd4,
      CSR_BASE_X       = 3'd5,
      CSR_BASE_Y       = 3'd6,
      CSR_BASE_Z       = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      PLANE_XY   = 2'd0,
      PLANE_YZ   = 2'd1,
      PLANE_XZ   = 2'd2,
      PLANE_NONE = 2'd3
   } plane_type;

   localparam int LAYOUT_CENTER_BIT = 2;

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                       input logic [COUNT_W-1:0] maxv);
      logic [COUNT_W-1:0] r;
      if (v == '0) begin
         r = COUNT_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [POS_W-1:0] r;
      // in range when the sign bit of the result and all bits above it agree
      if (v[SUM_W-1:POS_W-1] == '0 || v[SUM_W-1:POS_W-1] == '1) begin
         r = v[POS_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = POS_MIN;
      end else begin
         r = POS_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gip_divider.sv =====
`default_nettype none

module gip_divider import gip_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  logic [IDX_W-1:0]      dividend,
   input  logic [COUNT_W-1:0]    divisor,
   input  logic                  tag_in,
   output logic [IDX_W-1:0]      quotient,
   output logic [COL_W-1:0]      remainder,
   output logic                  tag_out
);

   typedef struct packed {
      logic [COL_W-1:0] rem;
      logic [IDX_W-1:0] work;
      logic             tag;
   } div_state_type;

   // shift dividend bits out of the top of work, quotient bits in at the bottom
   function automatic div_state_type div_slice(input div_state_type s,
                                               input logic [COUNT_W-1:0] d);
      div_state_type      r;
      logic [COUNT_W-1:0] part;
      r = s;
      for (int i = 0; i < DIV_BITS; i++) begin
         part   = {r.rem, r.work[IDX_W-1]};
         r.work = {r.work[IDX_W-2:0], 1'b0};
         if (part >= d) begin
            part      = part - d;
            r.work[0] = 1'b1;
         end
         r.rem = part[COL_W-1:0];
      end
      return r;
   endfunction

   div_state_type stage_ff [DIV_STAGES];
   div_state_type stage_in [DIV_STAGES];

   always_comb begin
      div_state_type first;
      first       = '{rem: '0, work: dividend, tag: tag_in};
      stage_in[0] = div_slice(first, divisor);
      for (int s = 1; s < DIV_STAGES; s++) begin
         stage_in[s] = div_slice(stage_ff[s-1], divisor);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (stage_en[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign quotient  = stage_ff[DIV_STAGES-1].work;
   assign remainder = stage_ff[DIV_STAGES-1].rem;
   assign tag_out   = stage_ff[DIV_STAGES-1].tag;

endmodule

`default_nettype wire

// ===== hw/rtl/grid_item_position.sv =====
// Grid item position generator.
// req channel: one word per grid item. req_tuser selects the form: 0 takes
// item_index, 1 folds column_in + row_in * column_count into the index.
// rsp channel: one word per request with column and row index, the x/y/z
// position in signed Q48.1, and an out-of-grid flag in rsp_tuser.
// csr port: write-only registers, written one per cycle with csr_we; write
// them only while no request is in flight.
// Pipeline: ten register stages: input, index fold, five divider stages,
// factor, multiply, output; the input stage loads at the request edge, and
// a response shows on rsp_tvalid once its word is in the output stage.
// Throughput: one word per cycle while no stage is stalled; the divider
// resolves four quotient bits in each of its five stages. Stalls: each stage
// holds its word when the next one is full and stalled; empty stages keep
// filling, so req_tready stays high until all ten stages hold words.
// Reset: pipeline empties; registers return to one column, one row, zero
// steps, xy plane centered, zero base.
`default_nettype none

module grid_item_position import gip_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: item_index[19:0], column_in[29:20], row_in[39:30]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: opcode
   input  logic                   req_tuser,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rsp_tdata: column_index[9:0], row_index[29:10], pos_x[78:30],
   //            pos_y[127:79], pos_z[176:128], zero fill[183:177]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: out_of_range
   output logic                   rsp_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [COUNT_W-1:0]       column_count_ff;
   logic [COUNT_W-1:0]       row_count_ff;
   logic signed [STEP_W-1:0] column_step_ff;
   logic signed [STEP_W-1:0] row_step_ff;
   logic [LAYOUT_W-1:0]      layout_ff;
   logic signed [STEP_W-1:0] base_x_ff;
   logic signed [STEP_W-1:0] base_y_ff;
   logic signed [STEP_W-1:0] base_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COUNT_W'(1);
         row_count_ff    <= COUNT_W'(1);
         column_step_ff  <= '0;
         row_step_ff     <= '0;
         layout_ff       <= LAYOUT_W'(4);
         base_x_ff       <= '0;
         base_y_ff       <= '0;
         base_z_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_COLUMN_COUNT: column_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_wdata[COUNT_W-1:0];
            CSR_COLUMN_STEP:  column_step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_ROW_STEP:     row_step_ff     <= csr_wdata[STEP_W-1:0];
            CSR_LAYOUT:       layout_ff       <= csr_wdata[LAYOUT_W-1:0];
            CSR_BASE_X:       base_x_ff       <= csr_wdata[STEP_W-1:0];
            CSR_BASE_Y:       base_y_ff       <= csr_wdata[STEP_W-1:0];
            CSR_BASE_Z:       base_z_ff       <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   logic [COUNT_W-1:0] num_cols;
   logic [COUNT_W-1:0] num_rows;
   logic               centered;

   assign num_cols = clamp_count(column_count_ff, COUNT_W'(MAX_COLUMNS));
   assign num_rows = clamp_count(row_count_ff, COUNT_W'(MAX_ROWS));
   assign centered = layout_ff[LAYOUT_CENTER_BIT];

   // stage handshake: a stage loads when it is empty or its word moves on
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[STG_OUT] = !valid_ff[STG_OUT] || rsp_tready;
      for (int k = STG_OUT - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[STG_IN]) begin
            valid_ff[STG_IN] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_tready = stage_en[STG_IN];
   assign rsp_tvalid = valid_ff[STG_OUT];

   // input stage
   logic                opcode_ff;
   logic [IDX_W-1:0]    item_index_ff;
   logic [COL_W-1:0]    column_in_ff;
   logic [ROW_IN_W-1:0] row_in_ff;

   always_ff @(posedge clock) begin
      if (stage_en[STG_IN]) begin
         opcode_ff     <= req_tuser;
         item_index_ff <= req_tdata[IDX_W-1:0];
         column_in_ff  <= req_tdata[IDX_W +: COL_W];
         row_in_ff     <= req_tdata[IDX_W+COL_W +: ROW_IN_W];
      end
   end

   // index fold and grid size
   logic [GRID_W-1:0] fold_sum;
   logic [GRID_W-1:0] grid_in;
   logic [IDX_W-1:0]  index_in;
   logic [IDX_W-1:0]  index_ff;
   logic [GRID_W-1:0] grid_ff;

   assign fold_sum = GRID_W'(row_in_ff) * GRID_W'(num_cols) + GRID_W'(column_in_ff);
   assign grid_in  = GRID_W'(num_cols) * GRID_W'(num_rows);
   assign index_in = opcode_ff ? fold_sum[IDX_W-1:0] : item_index_ff;

   always_ff @(posedge clock) begin
      if (stage_en[STG_IDX]) begin
         index_ff <= index_in;
         grid_ff  <= grid_in;
      end
   end

   // split index into row and column
   logic [IDX_W-1:0] div_quotient;
   logic [COL_W-1:0] div_remainder;
   logic             div_oor;

   gip_divider u_divider (
      .clock     (clock),
      .stage_en  (stage_en[STG_DIV +: DIV_STAGES]),
      .dividend  (index_ff),
      .divisor   (num_cols),
      .tag_in    (GRID_W'(index_ff) >= grid_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .tag_out   (div_oor)
   );

   // scale factors: 2*col - (n-1) when centered, else 2*col
   logic [COUNT_W-1:0]          col_center;
   logic [COUNT_W-1:0]          row_center;
   logic signed [COL_FAC_W-1:0] col_fac_in;
   logic signed [ROW_FAC_W-1:0] row_fac_in;
   logic signed [COL_FAC_W-1:0] col_fac_ff;
   logic signed [ROW_FAC_W-1:0] row_fac_ff;
   logic [COL_W-1:0]            fac_column_ff;
   logic [IDX_W-1:0]            fac_row_ff;
   logic                        fac_oor_ff;

   assign col_center = centered ? num_cols - COUNT_W'(1) : '0;
   assign row_center = centered ? num_rows - COUNT_W'(1) : '0;
   assign col_fac_in = $signed({1'b0, div_remainder, 1'b0})
                     - $signed({{(COL_FAC_W-COUNT_W){1'b0}}, col_center});
   assign row_fac_in = $signed({1'b0, div_quotient, 1'b0})
                     - $signed({{(ROW_FAC_W-COUNT_W){1'b0}}, row_center});

   always_ff @(posedge clock) begin
      if (stage_en[STG_FAC]) begin
         col_fac_ff    <= col_fac_in;
         row_fac_ff    <= row_fac_in;
         fac_column_ff <= div_remainder;
         fac_row_ff    <= div_quotient;
         fac_oor_ff    <= div_oor;
      end
   end

   // multiply by the steps
   logic signed [COL_OFF_W-1:0] col_off_ff;
   logic signed [ROW_OFF_W-1:0] row_off_ff;
   logic [COL_W-1:0]            mul_column_ff;
   logic [IDX_W-1:0]            mul_row_ff;
   logic                        mul_oor_ff;

   always_ff @(posedge clock) begin
      if (stage_en[STG_MUL]) begin
         col_off_ff    <= COL_OFF_W'(col_fac_ff) * COL_OFF_W'(column_step_ff);
         row_off_ff    <= ROW_OFF_W'(row_fac_ff) * ROW_OFF_W'(row_step_ff);
         mul_column_ff <= fac_column_ff;
         mul_row_ff    <= fac_row_ff;
         mul_oor_ff    <= fac_oor_ff;
      end
   end

   // place offsets on the plane, add base, saturate
   logic signed [SUM_W-1:0] base_x2;
   logic signed [SUM_W-1:0] base_y2;
   logic signed [SUM_W-1:0] base_z2;
   logic signed [SUM_W-1:0] col_ext;
   logic signed [SUM_W-1:0] row_ext;
   logic signed [SUM_W-1:0] x_sum;
   logic signed [SUM_W-1:0] y_sum;
   logic signed [SUM_W-1:0] z_sum;

   assign base_x2 = $signed({{(SUM_W-STEP_W-1){base_x_ff[STEP_W-1]}}, base_x_ff, 1'b0});
   assign base_y2 = $signed({{(SUM_W-STEP_W-1){base_y_ff[STEP_W-1]}}, base_y_ff, 1'b0});
   assign base_z2 = $signed({{(SUM_W-STEP_W-1){base_z_ff[STEP_W-1]}}, base_z_ff, 1'b0});
   assign col_ext = SUM_W'(col_off_ff);
   assign row_ext = SUM_W'(row_off_ff);

   always_comb begin
      x_sum = base_x2;
      y_sum = base_y2;
      z_sum = base_z2;
      case (plane_type'(layout_ff[1:0]))
         PLANE_XY: begin
            x_sum = base_x2 + col_ext;
            y_sum = base_y2 + row_ext;
         end
         PLANE_YZ: begin
            y_sum = base_y2 + col_ext;
            z_sum = base_z2 + row_ext;
         end
         PLANE_XZ: begin
            x_sum = base_x2 + col_ext;
            z_sum = base_z2 + row_ext;
         end
         default: ;
      endcase
   end

   logic [COL_W-1:0]        out_column_ff;
   logic [IDX_W-1:0]        out_row_ff;
   logic signed [POS_W-1:0] pos_x_ff;
   logic signed [POS_W-1:0] pos_y_ff;
   logic signed [POS_W-1:0] pos_z_ff;
   logic                    out_oor_ff;

   always_ff @(posedge clock) begin
      if (stage_en[STG_OUT]) begin
         out_column_ff <= mul_column_ff;
         out_row_ff    <= mul_row_ff;
         pos_x_ff      <= sat_pos(x_sum);
         pos_y_ff      <= sat_pos(y_sum);
         pos_z_ff      <= sat_pos(z_sum);
         out_oor_ff    <= mul_oor_ff;
      end
   end

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, pos_z_ff, pos_y_ff, pos_x_ff,
                       out_row_ff, out_column_ff};
   assign rsp_tuser = out_oor_ff;

endmodule

`default_nettype wire
